[rtl/mtnp_pkg.sv]
// mtnp_pkg: item types shared by the track event parser modules
// no dependencies
`default_nettype none

package mtnp_pkg;

    localparam int TIME_W = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic              note_valid;
        logic [TIME_W-1:0] event_time;
        logic [7:0]        note_number;
        logic [3:0]        channel;
        logic              track_done;
        logic              track_error;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/mtnp_in_stage.sv]
// mtnp_in_stage: input register for the track event parser
// depends on mtnp_pkg
`default_nettype none

module mtnp_in_stage
    import mtnp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    input  wire logic     i_advance,
    output logic          o_item_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_stall      = r_valid && !i_advance;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/mtnp_parser.sv]
// mtnp_parser: parse state and per-byte decode of track events
// depends on mtnp_pkg
`default_nettype none

module mtnp_parser
    import mtnp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    output logic          o_res_valid,
    output t_out_item     o_res
);

    localparam int ACC_W = 7 * MAX_LENGTH_BYTES;
    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [6:0] {
        PH_DELTA   = 7'b0000001,
        PH_STATUS  = 7'b0000010,
        PH_METATYP = 7'b0000100,
        PH_LENGTH  = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_PARAM1  = 7'b0100000,
        PH_PARAM2  = 7'b1000000
    } t_phase;

    localparam logic [7:0] ST_SYSEX  = 8'hF0;
    localparam logic [7:0] ST_ESCAPE = 8'hF7;
    localparam logic [7:0] ST_META   = 8'hFF;
    localparam logic [3:0] HI_NOTEON = 4'h9;
    localparam logic [3:0] HI_PROG   = 4'hC;
    localparam logic [3:0] HI_PRESS  = 4'hD;

    t_phase              r_phase,  n_phase;
    logic [ACC_W-1:0]    r_acc,    n_acc;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [TIME_W-1:0]   r_time,   n_time;
    logic [7:0]          r_status, n_status;
    logic [7:0]          r_param,  n_param;
    logic [ACC_W-1:0]    r_skip,   n_skip;

    logic [7:0]       b;
    logic [ACC_W-1:0] take_acc;
    logic [CNT_W-1:0] take_cnt;
    logic             take_done;
    logic             one_byte;
    logic             note;

    assign b         = i_item.data_byte;
    assign take_acc  = ACC_W'({r_acc, b[6:0]});
    assign take_cnt  = r_cnt + CNT_W'(1);
    assign take_done = (take_cnt >= CNT_W'(MAX_LENGTH_BYTES)) || !b[7];
    assign one_byte  = (r_status[7:4] == HI_PROG) || (r_status[7:4] == HI_PRESS);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_time   = r_time;
        n_status = r_status;
        n_param  = r_param;
        n_skip   = r_skip;
        note     = 1'b0;
        case (r_phase)
            PH_STATUS: begin
                if (b == ST_SYSEX || b == ST_ESCAPE) begin
                    n_phase = PH_LENGTH;
                end else if (b == ST_META) begin
                    n_phase = PH_METATYP;
                end else if (b[7]) begin
                    n_status = b;
                    n_phase  = PH_PARAM1;
                end else begin
                    n_param = b;
                    n_phase = one_byte ? PH_DELTA : PH_PARAM2;
                end
            end
            PH_METATYP: begin
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (take_done) begin
                    n_skip  = take_acc;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = (take_acc == '0) ? PH_DELTA : PH_SKIP;
                end else begin
                    n_acc = take_acc;
                    n_cnt = take_cnt;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - ACC_W'(1);
                if (n_skip == '0) begin
                    n_phase = PH_DELTA;
                end
            end
            PH_PARAM1: begin
                n_param = b;
                n_phase = one_byte ? PH_DELTA : PH_PARAM2;
            end
            PH_PARAM2: begin
                note    = (r_status[7:4] == HI_NOTEON) && (b != 8'h00);
                n_phase = PH_DELTA;
            end
            default: begin
                if (take_done) begin
                    n_time  = r_time + TIME_W'(take_acc);
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_STATUS;
                end else begin
                    n_acc   = take_acc;
                    n_cnt   = take_cnt;
                    n_phase = PH_DELTA;
                end
            end
        endcase
    end

    always_comb begin
        o_res_valid       = note || i_item.last_byte;
        o_res.note_valid  = note;
        o_res.event_time  = note ? r_time : '0;
        o_res.note_number = note ? r_param : 8'h00;
        o_res.channel     = note ? r_status[3:0] : 4'h0;
        o_res.track_done  = i_item.last_byte;
        o_res.track_error = i_item.last_byte && ((n_phase != PH_DELTA) || (n_cnt != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_phase  <= PH_DELTA;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_time   <= '0;
            r_status <= 8'h00;
            r_param  <= 8'h00;
            r_skip   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_time   <= n_time;
            r_status <= n_status;
            r_param  <= n_param;
            r_skip   <= n_skip;
        end
    end

endmodule

`default_nettype wire

[rtl/midi_track_note_on_parser_core.sv]
// midi_track_note_on_parser_core: track event byte parser reporting note-on events
// path: each byte passes the input register, the parser decode and the output register
// throughput: one byte per cycle unless i_stall holds a pending result, set by the single decode step between registers
// reset: synchronous active-low i_rst_n empties both registers and clears parse state
// depends on mtnp_pkg, mtnp_in_stage, mtnp_parser
`default_nettype none

module midi_track_note_on_parser_core
    import mtnp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_data
);

    logic      in_valid;
    t_in_item  in_item;
    logic      advance;
    logic      res_valid;
    t_out_item res;
    logic      r_out_valid;
    t_out_item r_out;

    assign advance = in_valid && (!r_out_valid || !i_stall);

    mtnp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .i_advance    (advance),
        .o_item_valid (in_valid),
        .o_item       (in_item)
    );

    mtnp_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_item_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.note_valid || o_data.track_done))
        else $error("item with neither note nor track end");

    a_error_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.track_error) |-> o_data.track_done)
        else $error("track error without track end");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.note_valid) |->
            (o_data.event_time == '0 && o_data.note_number == 8'h00
             && o_data.channel == 4'h0))
        else $error("note fields set without a note");

    a_no_advance_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !advance)
        else $error("parser advanced into a stalled result register");
`endif

endmodule

`default_nettype wire

[tb/tb_midi_track_note_on_parser_core.sv]
// tb_midi_track_note_on_parser_core: self-checking bench for the track event parser,
// directed and random track byte streams checked against a behavioral parser
// depends on mtnp_pkg and midi_track_note_on_parser_core
`timescale 1ns / 100ps

module tb_midi_track_note_on_parser_core;
    import mtnp_pkg::*;

    localparam int MAX_LEN    = 4;
    localparam int WDOG_LIMIT = 2000;
    localparam int RAND_ITEMS = 450;
    localparam int QUIET_LO   = 200;
    localparam int QUIET_HI   = 450;

    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
    localparam logic [7:0] META_EVENT   = 8'hFF;
    localparam logic [7:0] SYS_QFRAME   = 8'hF1;
    localparam logic [7:0] META_EOT     = 8'h2F;

    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_POLY_AT  = 4'hA;
    localparam logic [3:0] MSG_CTRL     = 4'hB;
    localparam logic [3:0] MSG_PROGRAM  = 4'hC;
    localparam logic [3:0] MSG_CHAN_AT  = 4'hD;
    localparam logic [3:0] MSG_PITCH    = 4'hE;

    typedef enum logic [2:0] {
        PH_DELTA, PH_STATUS, PH_META_TYPE, PH_LENGTH, PH_SKIP, PH_PARAM1, PH_PARAM2
    } t_phase;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;

    midi_track_note_on_parser_core #(.MAX_LENGTH_BYTES(MAX_LEN)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // parser state
    t_phase      ph;
    logic [27:0] vlq_acc;
    logic [2:0]  vlq_cnt;
    logic [31:0] abs_time;
    logic [7:0]  run_status;
    logic [7:0]  param_a;
    logic [27:0] skip_cnt;

    t_in_item  pend_q[$];
    t_out_item event_q[$];

    int cyc      = 0;
    int idle_cyc = 0;
    int n_fail   = 0;
    int n_gen    = 0;
    int n_in     = 0;
    int n_notes  = 0;
    int n_tracks = 0;
    int n_errs   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit roll_idle();
        return !(cyc >= QUIET_LO && cyc < QUIET_HI) && ($urandom_range(99) < 13);
    endfunction

    task automatic clear_track();
        ph         = PH_DELTA;
        vlq_acc    = '0;
        vlq_cnt    = '0;
        abs_time   = '0;
        run_status = '0;
        param_a    = '0;
        skip_cnt   = '0;
    endtask

    function automatic bit vlq_push(input logic [7:0] b);
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        vlq_cnt = vlq_cnt + 3'd1;
        return (vlq_cnt >= 3'(MAX_LEN)) || !b[7];
    endfunction

    function automatic bit one_data_byte();
        return run_status[7:4] == MSG_PROGRAM || run_status[7:4] == MSG_CHAN_AT;
    endfunction

    task automatic parse_byte(input t_in_item it);
        t_out_item   r;
        logic [7:0]  b;
        b = it.data_byte;
        r = '0;
        case (ph)
            PH_STATUS: begin
                if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
                    ph = PH_LENGTH;
                end else if (b == META_EVENT) begin
                    ph = PH_META_TYPE;
                end else if (b[7]) begin
                    run_status = b;
                    ph = PH_PARAM1;
                end else begin
                    param_a = b;
                    ph = one_data_byte() ? PH_DELTA : PH_PARAM2;
                end
            end
            PH_META_TYPE: ph = PH_LENGTH;
            PH_LENGTH: begin
                if (vlq_push(b)) begin
                    skip_cnt = vlq_acc;
                    vlq_acc  = '0;
                    vlq_cnt  = '0;
                    ph = (skip_cnt == 0) ? PH_DELTA : PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_cnt = skip_cnt - 28'd1;
                if (skip_cnt == 0) ph = PH_DELTA;
            end
            PH_PARAM1: begin
                param_a = b;
                ph = one_data_byte() ? PH_DELTA : PH_PARAM2;
            end
            PH_PARAM2: begin
                if (run_status[7:4] == MSG_NOTE_ON && b != 8'd0) begin
                    r.note_valid  = 1'b1;
                    r.event_time  = abs_time;
                    r.note_number = param_a;
                    r.channel     = run_status[3:0];
                end
                ph = PH_DELTA;
            end
            default: begin
                if (vlq_push(b)) begin
                    abs_time = abs_time + {4'd0, vlq_acc};
                    vlq_acc  = '0;
                    vlq_cnt  = '0;
                    ph = PH_STATUS;
                end else begin
                    ph = PH_DELTA;
                end
            end
        endcase
        if (r.note_valid || it.last_byte) begin
            r.track_done = it.last_byte;
            if (it.last_byte) begin
                r.track_error = (ph != PH_DELTA) || (vlq_cnt != 0);
                clear_track();
            end
            event_q.insert(event_q.size(), r);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (n_fail < 50) $display("mismatch %s: got %0h want %0h", what, got, want);
        n_fail++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        n_notes  += int'(got.note_valid);
        n_tracks += int'(got.track_done);
        n_errs   += int'(got.track_error);
        if (event_q.size() == 0) begin
            report("unexpected item", 32'(got.note_valid), 0);
        end else begin
            want = event_q.pop_front();
            if (got.note_valid !== want.note_valid)
                report("note_valid", 32'(got.note_valid), 32'(want.note_valid));
            if (got.event_time !== want.event_time)
                report("event_time", got.event_time, want.event_time);
            if (got.note_number !== want.note_number)
                report("note_number", 32'(got.note_number), 32'(want.note_number));
            if (got.channel !== want.channel)
                report("channel", 32'(got.channel), 32'(want.channel));
            if (got.track_done !== want.track_done)
                report("track_done", 32'(got.track_done), 32'(want.track_done));
            if (got.track_error !== want.track_error)
                report("track_error", 32'(got.track_error), 32'(want.track_error));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_track();
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_data);
                n_in++;
            end
            if (!i_valid || !o_stall) begin
                if (pend_q.size() > 0 && !roll_idle()) begin
                    i_data  <= pend_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_result(o_data);
            i_stall <= roll_idle();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic put(input logic [7:0] b);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = 1'b0;
        pend_q.insert(pend_q.size(), it);
        n_gen++;
    endtask

    task automatic put_vlq(input logic [27:0] value, input int nb);
        logic [7:0] b;
        for (int k = nb - 1; k >= 0; k--) begin
            b = {1'b0, 7'((value >> (7 * k)) & 28'h7F)};
            if (k > 0) b[7] = 1'b1;
            put(b);
        end
    endtask

    task automatic put_delta();
        case ($urandom_range(9))
            5, 6:    put_vlq(28'($urandom_range(16383)), 2);
            7:       put_vlq(28'($urandom_range(2097151)), 3);
            8:       put_vlq(28'($urandom), 4);
            9:       repeat (MAX_LEN) put(8'($urandom_range(128, 255)));
            default: put_vlq(28'($urandom_range(127)), 1);
        endcase
    endtask

    task automatic put_skipped(input logic [7:0] lead);
        int len;
        len = $urandom_range(4);
        put(lead);
        if (lead == META_EVENT) put(8'($urandom_range(255)));
        put_vlq(28'(len), $urandom_range(3) == 0 ? 2 : 1);
        repeat (len) put(8'($urandom_range(255)));
    endtask

    task automatic put_event();
        int         kind;
        logic [3:0] hi;
        kind = $urandom_range(99);
        if (kind < 40) begin
            if ($urandom_range(1)) put({MSG_NOTE_ON, 4'($urandom_range(15))});
            put(8'($urandom_range(127)));
            put($urandom_range(4) == 0 ? 8'd0 : 8'($urandom_range(1, 127)));
        end else if (kind < 55) begin
            case ($urandom_range(3))
                0:       hi = MSG_NOTE_OFF;
                1:       hi = MSG_POLY_AT;
                2:       hi = MSG_CTRL;
                default: hi = MSG_PITCH;
            endcase
            put({hi, 4'($urandom_range(15))});
            put(8'($urandom_range(127)));
            put(8'($urandom_range(127)));
        end else if (kind < 65) begin
            put({$urandom_range(1) ? MSG_PROGRAM : MSG_CHAN_AT, 4'($urandom_range(15))});
            put(8'($urandom_range(127)));
        end else if (kind < 75) begin
            put_skipped($urandom_range(1) ? SYSEX_START : SYSEX_ESCAPE);
        end else if (kind < 87) begin
            put_skipped(META_EVENT);
        end else begin
            hi = 4'($urandom_range(1, 14));
            if (hi == 4'h7) hi = 4'h1;
            put({4'hF, hi});
            put(8'($urandom_range(127)));
            put(8'($urandom_range(127)));
        end
    endtask

    task automatic put_track();
        int start;
        int kind;
        int cut;
        start = pend_q.size();
        kind  = $urandom_range(9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                put_delta();
                put_event();
            end
            // truncated track, usually ends inside an event
            if (kind == 1) begin
                cut = $urandom_range(1, 3);
                if (cut > pend_q.size() - start - 1) cut = pend_q.size() - start - 1;
                repeat (cut) begin
                    void'(pend_q.pop_back());
                    n_gen--;
                end
            end
        end
        pend_q[pend_q.size() - 1].last_byte = 1'b1;
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || i_valid || event_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no running status yet, then note-on on channel 15
        put(8'h00); put(8'h30); put(8'h40);
        put(8'h00); put({MSG_NOTE_ON, 4'hF}); put(8'h7F); put(8'h01);
        // over-long delta time, then a one-byte sysex
        put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF);
        put(SYSEX_START); put(8'h01); put(8'hAA);
        // running status survives the sysex, note 0
        put(8'h00); put(8'h00); put(8'h7F);
        put(8'h00); put(SYS_QFRAME); put(8'h12); put(8'h34);
        // zero-length meta ends the track cleanly
        put(8'h00); put(META_EVENT); put(META_EOT); put(8'h00);
        pend_q[pend_q.size() - 1].last_byte = 1'b1;
        // track ends inside a channel pressure event
        put(8'h00); put({MSG_CHAN_AT, 4'h2});
        pend_q[pend_q.size() - 1].last_byte = 1'b1;
        wait_drained();

        n_gen = 0;
        while (n_gen < RAND_ITEMS / 2) put_track();
        wait_drained();
        while (n_gen < RAND_ITEMS) put_track();
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (event_q.size() != 0) report("items never seen", 0, event_q.size());
        $display("%0d bytes parsed, %0d tracks ended (%0d with errors), %0d notes reported",
                 n_in, n_tracks, n_errs, n_notes);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
